/* src/eflh_pkg.sv */
// ----------------------------------------------------------------------------
// eflh_pkg
// Types, constants and address helpers shared by the heap allocator files.
// ----------------------------------------------------------------------------
package eflh_pkg;

    localparam int HEAP_WORDS = 8192;
    localparam int HEAP_LIMIT = (HEAP_WORDS * 8 < 65536) ? HEAP_WORDS * 8 : 65536;
    localparam int MEM_WORDS  = HEAP_LIMIT / 8;
    localparam int IDX_W      = $clog2(MEM_WORDS);
    localparam int STEPS_W    = $clog2(MEM_WORDS + 1);
    localparam int WORD_W     = 17;
    localparam int BA_W       = 18;
    localparam int LINK_W     = 16;
    localparam int CHUNK_W    = 13;

    localparam logic [WORD_W-1:0]  SIZE_MASK   = 17'h1FFF8;
    localparam logic [WORD_W-1:0]  MIN_BLOCK   = 17'd40;
    localparam logic [WORD_W-1:0]  TAG_BYTES   = 17'd16;
    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 13'd256;

    localparam logic [1:0] ACT_INIT  = 2'd0;
    localparam logic [1:0] ACT_ALLOC = 2'd1;
    localparam logic [1:0] ACT_FREE  = 2'd2;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_IGNORED = 2'd1;
    localparam logic [1:0] STAT_NOMEM   = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [15:0]       request_size;
        logic [15:0]       payload_address;
    } in_word_t;

    typedef struct packed {
        logic [15:0]       result_address;
        logic [1:0]        status;
    } out_word_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [WORD_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

    function automatic logic in_heap(input logic [BA_W-1:0] a);
        return a < BA_W'(HEAP_LIMIT);
    endfunction

    function automatic logic [IDX_W-1:0] word_idx(input logic [BA_W-1:0] a);
        return a[IDX_W+2:3];
    endfunction

endpackage

/* src/eflh_ram.sv */
// ----------------------------------------------------------------------------
// eflh_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module eflh_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 17
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/eflh_seq.sv */
// ----------------------------------------------------------------------------
// eflh_seq
// Request sequencer: init, first-fit allocate with split, free with
// coalescing, one heap memory access per cycle.
// ----------------------------------------------------------------------------
module eflh_seq
    import eflh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_word_t          in_word,
    output logic              out_valid,
    input  logic              out_stall,
    output out_word_t         out_word,
    input  logic [WORD_W-1:0] chunk_eff,
    output mem_req_t          mem_req,
    input  logic [WORD_W-1:0] ram_q
);

    typedef enum logic [5:0] {
        S_IDLE, S_INIT0, S_INIT1, S_INIT_G, S_INIT_P,
        S_GROW0, S_GROW1, S_GROW2, S_SB0, S_SB1,
        S_MG0, S_MG1, S_MG2, S_MG3, S_MG4, S_MG5A, S_MG5B, S_MG6, S_MG_RETP,
        S_UL0, S_UL1, S_UL2, S_UL3, S_PU0, S_PU1, S_PU2,
        S_A_CHK, S_FF0, S_FF1, S_FF2, S_NOFIT, S_A_G, S_FIT,
        S_CV0, S_CV1, S_CV2, S_CV3, S_A_FIN,
        S_F_CHK, S_F1, S_F2, S_F3, S_F4, S_F5, S_DONE
    } state_t;

    state_t              state_reg, sb_ret_reg, ul_ret_reg, pu_ret_reg;
    state_t              mg_ret_reg, gr_ret_reg;
    logic [15:0]         rsize_reg, paddr_reg;
    logic                cont_alloc_reg;
    logic [WORD_W-1:0]   brk_reg;
    logic [LINK_W-1:0]   head_reg;
    logic                ready_reg;
    logic [STEPS_W-1:0]  steps_reg;
    logic [WORD_W-1:0]   asize_reg, size_reg, psize_reg, nsize_reg, hdr_reg;
    logic [WORD_W-1:0]   gr_size_reg, sb_v_reg;
    logic [BA_W-1:0]     bb_reg, prv_reg, nxt_reg, sb_a_reg, ul_x_reg, pu_x_reg;
    logic [LINK_W-1:0]   ul_n_reg, ul_p_reg;
    logic                pa_reg, na_reg, gr_ok_reg;
    logic [1:0]          status_reg;
    logic [15:0]         raddr_res_reg;
    logic                out_valid_reg;
    out_word_t           out_word_reg;
    logic                oob_reg;

    logic [WORD_W-1:0]   rdata;
    logic [WORD_W-1:0]   rsize_blk;
    logic [BA_W-1:0]     rd_a, wr_a;
    logic                wr_en;
    logic [WORD_W-1:0]   wr_d;
    logic [WORD_W+1:0]   sum3;
    logic [WORD_W-1:0]   asize_calc, ext_size;
    logic                accept;

    assign rdata     = oob_reg ? '0 : ram_q;
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign rsize_blk  = (({1'b0, rsize_reg} + TAG_BYTES) < MIN_BLOCK) ? MIN_BLOCK
                        : ({1'b0, rsize_reg} + TAG_BYTES);
    assign asize_calc = (rsize_blk + WORD_W'(7)) & SIZE_MASK;
    assign ext_size   = (chunk_eff > asize_reg) ? chunk_eff : asize_reg;
    assign sum3       = (WORD_W+2)'(size_reg) + (WORD_W+2)'(psize_reg)
                        + (WORD_W+2)'(nsize_reg);

    // heap memory access for the current step
    always_comb
    begin
        rd_a  = '0;
        wr_en = 1'b0;
        wr_a  = '0;
        wr_d  = '0;
        case (state_reg)
            S_INIT0:
            begin
                wr_en = 1'b1;
                wr_a  = BA_W'(0);
                wr_d  = WORD_W'(9);
            end
            S_INIT1:
            begin
                wr_en = 1'b1;
                wr_a  = BA_W'(8);
                wr_d  = WORD_W'(1);
            end
            S_SB0:
            begin
                wr_en = 1'b1;
                wr_a  = sb_a_reg;
                wr_d  = sb_v_reg;
            end
            S_SB1:
            begin
                wr_en = 1'b1;
                wr_a  = sb_a_reg + BA_W'(sb_v_reg & SIZE_MASK) - BA_W'(8);
                wr_d  = sb_v_reg;
            end
            S_GROW1:
            begin
                // new epilogue sits one word below the new break
                wr_en = 1'b1;
                wr_a  = BA_W'(brk_reg) - BA_W'(8);
                wr_d  = WORD_W'(1);
            end
            S_MG0:     rd_a = bb_reg;
            S_MG1:     rd_a = bb_reg - BA_W'(8);
            S_MG2:     rd_a = bb_reg - BA_W'(rdata & SIZE_MASK);
            S_MG3:     rd_a = nxt_reg;
            S_UL0:     rd_a = ul_x_reg + BA_W'(8);
            S_UL1:     rd_a = ul_x_reg + BA_W'(16);
            S_UL2:
            begin
                wr_en = (rdata[LINK_W-1:0] != '0);
                wr_a  = BA_W'(rdata[LINK_W-1:0]) + BA_W'(8);
                wr_d  = WORD_W'(ul_n_reg);
            end
            S_UL3:
            begin
                wr_en = (ul_n_reg != '0);
                wr_a  = BA_W'(ul_n_reg) + BA_W'(16);
                wr_d  = WORD_W'(ul_p_reg);
            end
            S_PU0:
            begin
                wr_en = 1'b1;
                wr_a  = pu_x_reg + BA_W'(8);
                wr_d  = WORD_W'(head_reg);
            end
            S_PU1:
            begin
                wr_en = (head_reg != '0);
                wr_a  = BA_W'(head_reg) + BA_W'(16);
                wr_d  = pu_x_reg[WORD_W-1:0];
            end
            S_PU2:
            begin
                wr_en = 1'b1;
                wr_a  = pu_x_reg + BA_W'(16);
                wr_d  = '0;
            end
            S_FF0:     rd_a = bb_reg;
            S_FF1:     rd_a = bb_reg + BA_W'(8);
            S_CV0:     rd_a = bb_reg;
            S_F_CHK:   rd_a = BA_W'(paddr_reg) - BA_W'(8);
            S_F1:      rd_a = bb_reg + BA_W'(rdata & SIZE_MASK) - BA_W'(8);
            default:   rd_a = '0;
        endcase
    end

    assign mem_req.we    = wr_en && in_heap(wr_a);
    assign mem_req.waddr = word_idx(wr_a);
    assign mem_req.wdata = wr_d;
    assign mem_req.raddr = word_idx(rd_a);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            brk_reg       <= '0;
            head_reg      <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            oob_reg       <= 1'b0;
        end
        else
        begin
            oob_reg <= !in_heap(rd_a);
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        rsize_reg      <= in_word.request_size;
                        paddr_reg      <= in_word.payload_address;
                        raddr_res_reg  <= '0;
                        cont_alloc_reg <= 1'b0;
                        if (in_word.action == ACT_INIT)
                        begin
                            state_reg <= S_INIT0;
                        end
                        else if (in_word.action == ACT_ALLOC)
                        begin
                            cont_alloc_reg <= 1'b1;
                            state_reg      <= ready_reg ? S_A_CHK : S_INIT0;
                        end
                        else if (in_word.action == ACT_FREE)
                        begin
                            state_reg <= S_F_CHK;
                        end
                        else
                        begin
                            status_reg <= STAT_IGNORED;
                            state_reg  <= S_DONE;
                        end
                    end
                end
                S_INIT0:
                begin
                    head_reg  <= '0;
                    state_reg <= S_INIT1;
                end
                S_INIT1:
                begin
                    brk_reg     <= WORD_W'(16);
                    ready_reg   <= 1'b1;
                    gr_size_reg <= chunk_eff;
                    gr_ret_reg  <= S_INIT_G;
                    state_reg   <= S_GROW0;
                end
                S_INIT_G:
                begin
                    if (!gr_ok_reg)
                    begin
                        status_reg <= STAT_NOMEM;
                        state_reg  <= cont_alloc_reg ? S_A_CHK : S_DONE;
                    end
                    else
                    begin
                        pu_x_reg   <= bb_reg;
                        pu_ret_reg <= S_INIT_P;
                        state_reg  <= S_PU0;
                    end
                end
                S_INIT_P:
                begin
                    status_reg <= STAT_DONE;
                    state_reg  <= cont_alloc_reg ? S_A_CHK : S_DONE;
                end
                S_GROW0:
                begin
                    if ((BA_W'(brk_reg) + BA_W'(gr_size_reg)) > BA_W'(HEAP_LIMIT))
                    begin
                        gr_ok_reg <= 1'b0;
                        state_reg <= gr_ret_reg;
                    end
                    else
                    begin
                        bb_reg     <= BA_W'(brk_reg) - BA_W'(8);
                        sb_a_reg   <= BA_W'(brk_reg) - BA_W'(8);
                        sb_v_reg   <= gr_size_reg;
                        brk_reg    <= brk_reg + gr_size_reg;
                        sb_ret_reg <= S_GROW1;
                        state_reg  <= S_SB0;
                    end
                end
                S_GROW1:
                begin
                    mg_ret_reg <= S_GROW2;
                    state_reg  <= S_MG0;
                end
                S_GROW2:
                begin
                    gr_ok_reg <= 1'b1;
                    state_reg <= gr_ret_reg;
                end
                S_SB0:     state_reg <= S_SB1;
                S_SB1:     state_reg <= sb_ret_reg;
                S_MG0:     state_reg <= S_MG1;
                S_MG1:
                begin
                    size_reg  <= rdata & SIZE_MASK;
                    nxt_reg   <= bb_reg + BA_W'(rdata & SIZE_MASK);
                    state_reg <= S_MG2;
                end
                S_MG2:
                begin
                    prv_reg   <= rd_a;
                    state_reg <= S_MG3;
                end
                S_MG3:
                begin
                    pa_reg    <= rdata[0];
                    psize_reg <= rdata & SIZE_MASK;
                    state_reg <= S_MG4;
                end
                S_MG4:
                begin
                    na_reg <= rdata[0];
                    if (pa_reg && rdata[0])
                    begin
                        state_reg <= mg_ret_reg;
                    end
                    else if (!pa_reg && rdata[0])
                    begin
                        size_reg   <= (size_reg + psize_reg) & SIZE_MASK;
                        sb_v_reg   <= (size_reg + psize_reg) & SIZE_MASK;
                        sb_a_reg   <= prv_reg;
                        sb_ret_reg <= S_MG5A;
                        state_reg  <= S_SB0;
                    end
                    else if (pa_reg)
                    begin
                        size_reg   <= (size_reg + (rdata & SIZE_MASK)) & SIZE_MASK;
                        sb_v_reg   <= (size_reg + (rdata & SIZE_MASK)) & SIZE_MASK;
                        sb_a_reg   <= bb_reg;
                        sb_ret_reg <= S_MG5B;
                        state_reg  <= S_SB0;
                    end
                    else
                    begin
                        nsize_reg  <= rdata & SIZE_MASK;
                        sb_a_reg   <= prv_reg;
                        sb_ret_reg <= S_MG5A;
                        state_reg  <= S_MG6;
                    end
                end
                S_MG6:
                begin
                    // both neighbors free: set tags of the merged block
                    size_reg  <= sum3[WORD_W-1:0] & SIZE_MASK;
                    sb_v_reg  <= sum3[WORD_W-1:0] & SIZE_MASK;
                    na_reg    <= 1'b0;
                    state_reg <= S_SB0;
                end
                S_MG5A:
                begin
                    ul_x_reg   <= prv_reg;
                    ul_ret_reg <= na_reg ? S_MG_RETP : S_MG5B;
                    state_reg  <= S_UL0;
                end
                S_MG5B:
                begin
                    ul_x_reg   <= nxt_reg;
                    ul_ret_reg <= (!pa_reg && !na_reg) ? S_MG_RETP : mg_ret_reg;
                    state_reg  <= S_UL0;
                end
                S_MG_RETP:
                begin
                    bb_reg    <= prv_reg;
                    state_reg <= mg_ret_reg;
                end
                S_UL0:     state_reg <= S_UL1;
                S_UL1:
                begin
                    ul_n_reg  <= rdata[LINK_W-1:0];
                    state_reg <= S_UL2;
                end
                S_UL2:
                begin
                    ul_p_reg <= rdata[LINK_W-1:0];
                    if (rdata[LINK_W-1:0] == '0)
                    begin
                        head_reg <= ul_n_reg;
                    end
                    state_reg <= S_UL3;
                end
                S_UL3:     state_reg <= ul_ret_reg;
                S_PU0:     state_reg <= S_PU1;
                S_PU1:     state_reg <= S_PU2;
                S_PU2:
                begin
                    head_reg  <= pu_x_reg[LINK_W-1:0];
                    state_reg <= pu_ret_reg;
                end
                S_A_CHK:
                begin
                    if (rsize_reg == '0)
                    begin
                        status_reg <= STAT_IGNORED;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        asize_reg <= asize_calc;
                        bb_reg    <= BA_W'(head_reg);
                        steps_reg <= STEPS_W'(MEM_WORDS);
                        state_reg <= S_FF0;
                    end
                end
                S_FF0:
                begin
                    state_reg <= (bb_reg == '0 || steps_reg == '0) ? S_NOFIT : S_FF1;
                end
                S_FF1:
                begin
                    if ((rdata & SIZE_MASK) >= asize_reg && !rdata[0])
                    begin
                        state_reg <= S_FIT;
                    end
                    else
                    begin
                        state_reg <= S_FF2;
                    end
                end
                S_FF2:
                begin
                    bb_reg    <= BA_W'(rdata[LINK_W-1:0]);
                    steps_reg <= steps_reg - STEPS_W'(1);
                    state_reg <= S_FF0;
                end
                S_NOFIT:
                begin
                    gr_size_reg <= ext_size;
                    gr_ret_reg  <= S_A_G;
                    state_reg   <= S_GROW0;
                end
                S_A_G:
                begin
                    if (!gr_ok_reg)
                    begin
                        status_reg <= STAT_NOMEM;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        pu_x_reg   <= bb_reg;
                        pu_ret_reg <= S_FIT;
                        state_reg  <= S_PU0;
                    end
                end
                S_FIT:
                begin
                    ul_x_reg   <= bb_reg;
                    ul_ret_reg <= S_CV0;
                    state_reg  <= S_UL0;
                end
                S_CV0:     state_reg <= S_CV1;
                S_CV1:
                begin
                    size_reg <= rdata & SIZE_MASK;
                    sb_a_reg <= bb_reg;
                    if ((BA_W'(rdata & SIZE_MASK)) >= (BA_W'(MIN_BLOCK) + BA_W'(asize_reg)))
                    begin
                        sb_v_reg   <= asize_reg | WORD_W'(1);
                        sb_ret_reg <= S_CV2;
                    end
                    else
                    begin
                        sb_v_reg   <= (rdata & SIZE_MASK) | WORD_W'(1);
                        sb_ret_reg <= S_A_FIN;
                    end
                    state_reg <= S_SB0;
                end
                S_CV2:
                begin
                    sb_a_reg   <= bb_reg + BA_W'(asize_reg);
                    sb_v_reg   <= size_reg - asize_reg;
                    sb_ret_reg <= S_CV3;
                    state_reg  <= S_SB0;
                end
                S_CV3:
                begin
                    pu_x_reg   <= bb_reg + BA_W'(asize_reg);
                    pu_ret_reg <= S_A_FIN;
                    state_reg  <= S_PU0;
                end
                S_A_FIN:
                begin
                    raddr_res_reg <= bb_reg[LINK_W-1:0] + LINK_W'(8);
                    status_reg    <= STAT_DONE;
                    state_reg     <= S_DONE;
                end
                S_F_CHK:
                begin
                    bb_reg <= BA_W'(paddr_reg) - BA_W'(8);
                    if (paddr_reg == '0 || !ready_reg || paddr_reg[2:0] != 3'd0
                        || paddr_reg < 16'd16)
                    begin
                        status_reg <= STAT_IGNORED;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_F1;
                    end
                end
                S_F1:
                begin
                    hdr_reg  <= rdata;
                    size_reg <= rdata & SIZE_MASK;
                    if (!rdata[0] || (rdata & SIZE_MASK) < MIN_BLOCK
                        || (bb_reg + BA_W'(rdata & SIZE_MASK) + BA_W'(8)) > BA_W'(brk_reg))
                    begin
                        status_reg <= STAT_IGNORED;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_F2;
                    end
                end
                S_F2:
                begin
                    if (rdata != hdr_reg)
                    begin
                        status_reg <= STAT_IGNORED;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        sb_a_reg   <= bb_reg;
                        sb_v_reg   <= size_reg;
                        sb_ret_reg <= S_F3;
                        state_reg  <= S_SB0;
                    end
                end
                S_F3:
                begin
                    mg_ret_reg <= S_F4;
                    state_reg  <= S_MG0;
                end
                S_F4:
                begin
                    pu_x_reg   <= bb_reg;
                    pu_ret_reg <= S_F5;
                    state_reg  <= S_PU0;
                end
                S_F5:
                begin
                    status_reg <= STAT_DONE;
                    state_reg  <= S_DONE;
                end
                S_DONE:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg               <= 1'b1;
                        out_word_reg.result_address <= raddr_res_reg;
                        out_word_reg.status         <= status_reg;
                        state_reg                   <= S_IDLE;
                    end
                end
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* src/explicit_free_list_heap_allocator_top.sv */
// ----------------------------------------------------------------------------
// explicit_free_list_heap_allocator_top
// Requests are handled one at a time: in_stall stays high from acceptance
//   until the result word is loaded into the output register, which waits
//   on out_stall. The sequencer makes at most one heap memory access per cycle.
// Reset: asynchronous, active low; heap not ready, list empty, chunk 256.
// ----------------------------------------------------------------------------
module explicit_free_list_heap_allocator_top
    import eflh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [CHUNK_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_word_t           in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output out_word_t          out_word
);

    logic [CHUNK_W-1:0] chunk_reg;
    logic [CHUNK_W:0]   chunk_r8;
    logic [WORD_W-1:0]  chunk_eff;
    mem_req_t           mem_req;
    logic [WORD_W-1:0]  ram_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg <= CHUNK_RESET;
        end
        else if (cfg_write)
        begin
            chunk_reg <= cfg_data;
        end
    end

    // round up to eight, raise to the minimum block
    assign chunk_r8  = ({1'b0, chunk_reg} + (CHUNK_W+1)'(7)) & ~(CHUNK_W+1)'(7);
    assign chunk_eff = (WORD_W'(chunk_r8) < MIN_BLOCK) ? MIN_BLOCK : WORD_W'(chunk_r8);

    eflh_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .chunk_eff (chunk_eff),
        .mem_req   (mem_req),
        .ram_q     (ram_q)
    );

    eflh_ram #(
        .DEPTH (MEM_WORDS),
        .WIDTH (WORD_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (ram_q)
    );

endmodule

/* sim/tb_explicit_free_list_heap_allocator_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_explicit_free_list_heap_allocator_top
// Drives init, allocate, free and spare-action requests into the allocator and
// checks every result against a fixed word or a cycle-free boundary-tag model.
// ----------------------------------------------------------------------------
module tb_explicit_free_list_heap_allocator_top;
    import eflh_pkg::*;

    localparam int unsigned LIMIT_B = HEAP_LIMIT;
    localparam int unsigned MINBLK  = 40;
    localparam logic [1:0]  ACT_SPARE = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [CHUNK_W-1:0] cfg_data;
    logic               in_valid;
    logic               in_stall;
    in_word_t           in_word;
    logic               out_valid;
    logic               out_stall;
    out_word_t          out_word;

    explicit_free_list_heap_allocator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    // heap model state
    logic [16:0]  heap_mem [MEM_WORDS];
    bit           heap_seen [MEM_WORDS];
    int unsigned  heap_brk;
    int unsigned  list_head;
    bit           heap_up;
    int unsigned  chunk_reg;

    out_word_t    pending_results [$];
    int unsigned  live_blocks [$];
    int unsigned  stale_blocks [$];
    int           error_count;
    int           tx_idle_pct;
    int           rx_idle_pct;
    int           rx_hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = 1'b1;
            #2 clk = 1'b0;
        end
    end

    initial
    begin
        #20_000_000;
        $display("tb_explicit_free_list_heap_allocator_top: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        begin
            $display("ERROR %0t: %s", $realtime, msg);
            error_count++;
        end
    endtask

    // ---------------- heap model ----------------
    function automatic int unsigned heap_rd(input int unsigned a);
        if (a < LIMIT_B)
            return heap_mem[a >> 3];
        return 0;
    endfunction

    function automatic void heap_wr(input int unsigned a, input int unsigned v);
        if (a < LIMIT_B)
        begin
            heap_mem[a >> 3]  = v[16:0];
            heap_seen[a >> 3] = 1'b1;
        end
    endfunction

    function automatic bit word_known(input int unsigned a);
        return (a >= LIMIT_B) || heap_seen[a >> 3];
    endfunction

    function automatic int unsigned round_up8(input int unsigned v);
        return (v + 7) & ~32'd7;
    endfunction

    function automatic void put_tags(input int unsigned b, input int unsigned sz,
                                     input int unsigned al);
        heap_wr(b, sz | al);
        heap_wr(b + sz - 8, sz | al);
    endfunction

    function automatic void push_free(input int unsigned b);
        heap_wr(b + 8, list_head);
        if (list_head != 0)
            heap_wr(list_head + 16, b);
        heap_wr(b + 16, 0);
        list_head = b & 32'hFFFF;
    endfunction

    function automatic void unlink_free(input int unsigned b);
        int unsigned n;
        int unsigned p;
        n = heap_rd(b + 8) & 32'hFFFF;
        p = heap_rd(b + 16) & 32'hFFFF;
        if (p == 0)
            list_head = n;
        else
            heap_wr(p + 8, n);
        if (n != 0)
            heap_wr(n + 16, p);
    endfunction

    function automatic int unsigned coalesce(input int unsigned b);
        int unsigned sz;
        int unsigned nb;
        int unsigned pb;
        bit          pa;
        bit          na;
        sz = heap_rd(b) & SIZE_MASK;
        nb = b + sz;
        pb = b - (heap_rd(b - 8) & SIZE_MASK);
        pa = ((heap_rd(pb) & 1) != 0);
        na = ((heap_rd(nb) & 1) != 0);
        if (pa && na)
            return b;
        if (!pa && na)
        begin
            sz = (sz + (heap_rd(pb) & SIZE_MASK)) & SIZE_MASK;
            put_tags(pb, sz, 0);
            unlink_free(pb);
            return pb;
        end
        if (pa && !na)
        begin
            sz = (sz + (heap_rd(nb) & SIZE_MASK)) & SIZE_MASK;
            put_tags(b, sz, 0);
            unlink_free(nb);
            return b;
        end
        sz = (sz + (heap_rd(nb) & SIZE_MASK) + (heap_rd(pb) & SIZE_MASK)) & SIZE_MASK;
        put_tags(pb, sz, 0);
        unlink_free(pb);
        unlink_free(nb);
        return pb;
    endfunction

    function automatic bit grow_heap(input int unsigned sz, output int unsigned blk);
        int unsigned b;
        sz = round_up8(sz);
        blk = 0;
        if (heap_brk + sz > LIMIT_B)
            return 1'b0;
        b = heap_brk - 8;
        heap_brk += sz;
        put_tags(b, sz, 0);
        heap_wr(b + sz, 1);
        blk = coalesce(b);
        return 1'b1;
    endfunction

    function automatic int unsigned chunk_size();
        int unsigned c;
        c = round_up8(chunk_reg);
        return (c < MINBLK) ? MINBLK : c;
    endfunction

    function automatic logic [1:0] start_heap();
        int unsigned b;
        heap_brk  = 0;
        list_head = 0;
        heap_wr(0, 9);
        heap_wr(8, 1);
        heap_brk = 16;
        heap_up  = 1'b1;
        if (!grow_heap(chunk_size(), b))
            return STAT_NOMEM;
        push_free(b);
        return STAT_DONE;
    endfunction

    function automatic int unsigned scan_list(input int unsigned asz);
        int unsigned b;
        int unsigned steps;
        int unsigned h;
        b = list_head;
        steps = LIMIT_B / 8;
        while (b != 0 && steps != 0)
        begin
            h = heap_rd(b);
            if ((h & SIZE_MASK) >= asz && (h & 1) == 0)
                return b;
            b = heap_rd(b + 8) & 32'hFFFF;
            steps--;
        end
        return 0;
    endfunction

    function automatic out_word_t model_alloc(input int unsigned req);
        out_word_t   r;
        int unsigned asz;
        int unsigned b;
        int unsigned bsz;
        int unsigned ext;
        r.result_address = '0;
        if (!heap_up)
            void'(start_heap());
        if (req == 0)
        begin
            r.status = STAT_IGNORED;
            return r;
        end
        asz = req + 16;
        if (asz < MINBLK)
            asz = MINBLK;
        asz = round_up8(asz);
        b = scan_list(asz);
        if (b == 0)
        begin
            ext = (chunk_size() > asz) ? chunk_size() : asz;
            if (!grow_heap(ext, b))
            begin
                r.status = STAT_NOMEM;
                return r;
            end
            push_free(b);
        end
        unlink_free(b);
        bsz = heap_rd(b) & SIZE_MASK;
        if (bsz >= MINBLK + asz)
        begin
            put_tags(b, asz, 1);
            put_tags(b + asz, bsz - asz, 0);
            push_free(b + asz);
        end
        else
            put_tags(b, bsz, 1);
        r.result_address = 16'(b + 8);
        r.status = STAT_DONE;
        return r;
    endfunction

    function automatic logic [1:0] model_free(input int unsigned a);
        int unsigned h;
        int unsigned hdr;
        int unsigned sz;
        if (a == 0 || !heap_up || (a & 7) != 0 || a < 16)
            return STAT_IGNORED;
        h = a - 8;
        hdr = heap_rd(h);
        sz = hdr & SIZE_MASK;
        if ((hdr & 1) == 0 || sz < MINBLK || h + sz + 8 > heap_brk)
            return STAT_IGNORED;
        if (heap_rd(h + sz - 8) != hdr)
            return STAT_IGNORED;
        put_tags(h, sz, 0);
        push_free(coalesce(h));
        return STAT_DONE;
    endfunction

    // true when a free of this address reads only words already written
    function automatic bit free_is_safe(input int unsigned a);
        int unsigned h;
        int unsigned hdr;
        int unsigned sz;
        if (a == 0 || !heap_up || (a & 7) != 0 || a < 16)
            return 1'b1;
        h = a - 8;
        if (!word_known(h))
            return 1'b0;
        hdr = heap_rd(h);
        sz = hdr & SIZE_MASK;
        if ((hdr & 1) == 0 || sz < MINBLK || h + sz + 8 > heap_brk)
            return 1'b1;
        return word_known(h + sz - 8);
    endfunction

    // advance the model by one request and keep the pools of addresses current
    function automatic out_word_t predict_word(input in_word_t w);
        out_word_t r;
        r.result_address = '0;
        case (w.action)
            ACT_INIT:
            begin
                r.status = start_heap();
                foreach (live_blocks[i])
                    stale_blocks.push_back(live_blocks[i]);
                live_blocks.delete();
            end
            ACT_ALLOC:
            begin
                r = model_alloc(w.request_size);
                if (r.status == STAT_DONE)
                    live_blocks.push_back(r.result_address);
            end
            ACT_FREE:
            begin
                r.status = model_free(w.payload_address);
                if (r.status == STAT_DONE)
                begin
                    foreach (live_blocks[i])
                        if (live_blocks[i] == w.payload_address)
                        begin
                            live_blocks.delete(i);
                            break;
                        end
                    stale_blocks.push_back(w.payload_address);
                end
            end
            default: r.status = STAT_IGNORED;
        endcase
        while (stale_blocks.size() > 32)
            void'(stale_blocks.pop_front());
        return r;
    endfunction

    // ---------------- stimulus ----------------
    function automatic in_word_t make_request();
        in_word_t    w;
        int unsigned r;
        int unsigned a;
        w.action          = ACT_ALLOC;
        w.request_size    = 16'($urandom);
        w.payload_address = 16'($urandom);
        r = $urandom_range(99);
        if (live_blocks.size() > 40 && r < 60)
            r = 60;
        if (r < 2)
            w.action = ACT_INIT;
        else if (r < 4)
            w.action = ACT_SPARE;
        else if (r < 55)
        begin
            r = $urandom_range(99);
            if (r < 4)
                w.request_size = 0;
            else if (r < 7)
                w.request_size = 16'($urandom_range(16'hFFFF, 16'hF000));
            else if (r < 15)
                w.request_size = 16'($urandom_range(4096, 257));
            else
                w.request_size = 16'($urandom_range(256, 1));
        end
        else
        begin
            w.action = ACT_FREE;
            r = $urandom_range(99);
            if (r < 80 && live_blocks.size() > 0)
                w.payload_address = 16'(live_blocks[$urandom_range(live_blocks.size() - 1)]);
            else if (r < 85)
                w.payload_address = 0;
            else if (r < 90)
                w.payload_address = 16'($urandom) | 16'd1;
            else
            begin
                if (r < 95 && stale_blocks.size() > 0)
                    a = stale_blocks[$urandom_range(stale_blocks.size() - 1)];
                else
                    a = $urandom_range(16'hFFFF) & ~32'd7;
                w.payload_address = free_is_safe(a) ? 16'(a) : 16'd0;
            end
        end
        return w;
    endfunction

    // call at a falling edge; returns at a falling edge after acceptance
    task automatic send_word(input in_word_t w, input bit use_typed, input out_word_t typed);
        out_word_t p;
        begin
            while ($urandom_range(99) < tx_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            in_word  <= w;
            do
                @(posedge clk);
            while (in_stall);
            p = predict_word(w);
            pending_results.push_back(use_typed ? typed : p);
            @(negedge clk);
        end
    endtask

    // hold until idle, then load the chunk register
    task automatic write_chunk(input int unsigned v);
        begin
            in_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(negedge clk);
            repeat (100) @(negedge clk);
            cfg_write <= 1'b1;
            cfg_data  <= CHUNK_W'(v);
            chunk_reg  = v;
            @(negedge clk);
            cfg_write <= 1'b0;
        end
    endtask

    // ---------------- receiver side ----------------
    always @(negedge clk)
    begin
        if (rx_hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            rx_hold_cycles--;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected word addr=%0d status=%0d",
                                          out_word.result_address, out_word.status));
            else
            begin
                e = pending_results.pop_front();
                if (out_word.result_address !== e.result_address)
                    report_mismatch($sformatf("result_address %0d, want %0d",
                                              out_word.result_address, e.result_address));
                if (out_word.status !== e.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              out_word.status, e.status));
            end
        end
    end

    // ---------------- main sequence ----------------
    typedef struct {
        logic [1:0]  act;
        int unsigned req;
        int unsigned addr;
        bit          typed;
        int unsigned want_addr;
        logic [1:0]  want_status;
    } req_row_t;

    localparam int N_ROWS = 19;
    req_row_t directed_rows [N_ROWS];
    int unsigned chunk_steps [6] = '{8, 4096, 4095, 40, 100, 1000};

    initial
    begin
        in_word_t  w;
        out_word_t t;
        int        guard;

        directed_rows = '{
            '{ACT_FREE,  0,     0,     1, 0,   STAT_IGNORED},
            '{ACT_ALLOC, 0,     0,     1, 0,   STAT_IGNORED},
            '{ACT_ALLOC, 1,     0,     1, 16,  STAT_DONE},
            '{ACT_ALLOC, 24,    0,     0, 0,   STAT_DONE},
            '{ACT_ALLOC, 65535, 0,     1, 0,   STAT_NOMEM},
            '{ACT_FREE,  0,     16,    1, 0,   STAT_DONE},
            '{ACT_FREE,  0,     16,    1, 0,   STAT_IGNORED},
            '{ACT_FREE,  0,     17,    1, 0,   STAT_IGNORED},
            '{ACT_FREE,  0,     65535, 1, 0,   STAT_IGNORED},
            '{ACT_FREE,  0,     8,     1, 0,   STAT_IGNORED},
            '{ACT_SPARE, 0,     0,     1, 0,   STAT_IGNORED},
            '{ACT_INIT,  0,     0,     1, 0,   STAT_DONE},
            '{ACT_ALLOC, 200,   0,     1, 16,  STAT_DONE},
            '{ACT_ALLOC, 1000,  0,     1, 232, STAT_DONE},
            '{ACT_ALLOC, 40,    0,     0, 0,   STAT_DONE},
            '{ACT_FREE,  0,     232,   0, 0,   STAT_DONE},
            '{ACT_FREE,  0,     16,    0, 0,   STAT_DONE},
            '{ACT_ALLOC, 4000,  0,     0, 0,   STAT_DONE},
            '{ACT_ALLOC, 65519, 0,     1, 0,   STAT_NOMEM}
        };

        error_count    = 0;
        tx_idle_pct    = 25;
        rx_idle_pct    = 63;
        rx_hold_cycles = 0;
        heap_brk       = 0;
        list_head      = 0;
        heap_up        = 1'b0;
        chunk_reg      = CHUNK_RESET;
        foreach (heap_mem[i])
        begin
            heap_mem[i]  = '0;
            heap_seen[i] = 1'b0;
        end
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_word   = '0;
        out_stall = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_ROWS; i++)
        begin
            w.action          = directed_rows[i].act;
            w.request_size    = 16'(directed_rows[i].req);
            w.payload_address = 16'(directed_rows[i].addr);
            t.result_address  = 16'(directed_rows[i].want_addr);
            t.status          = directed_rows[i].want_status;
            send_word(w, directed_rows[i].typed, t);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            write_chunk(chunk_steps[ph]);
            if (ph == 2)
            begin
                tx_idle_pct = 63;
                rx_idle_pct = 25;
            end
            else if (ph == 4)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // back up the output while requests keep coming
            if (ph == 1 || ph == 5)
                rx_hold_cycles = 600;
            for (int n = 0; n < 305; n++)
                send_word(make_request(), 1'b0, t);
        end
        in_valid <= 1'b0;

        guard = 0;
        while (pending_results.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (200) @(negedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", pending_results.size()));

        if (error_count == 0)
            $display("tb_explicit_free_list_heap_allocator_top: PASS");
        else
            $display("tb_explicit_free_list_heap_allocator_top: FAIL");
        $finish;
    end

endmodule

/* explicit_free_list_heap_allocator_top.f */
src/eflh_pkg.sv
src/eflh_ram.sv
src/eflh_seq.sv
src/explicit_free_list_heap_allocator_top.sv
sim/tb_explicit_free_list_heap_allocator_top.sv
